// ----- rtl/core/nivd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package nivd_pkg;
    typedef enum logic [1:0] {
        MODE_UPDATE  = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_TICK    = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_ASSIGNED = 2'd0,
        ST_RETRY    = 2'd1,
        ST_BAD_NODE = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_FULL  = 5'b10000
    } state_t;

    localparam int PERSON_W = 16;
    localparam int NODE_W   = 32;
    localparam int TICK_W   = 16;
    localparam int SLOT_W   = 5;
    localparam int DIST_W   = 25;

    // slot index and coordinate ports are sized for these
    localparam int VEHICLE_SLOTS = 32;
    localparam int COORD_BITS    = 24;
endpackage
`default_nettype wire

// ----- rtl/core/nivd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nivd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/nearest_idle_vehicle_dispatch.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Slot updates, queued requests and plain ticks are accepted only while idle.
// A dispatch round walks the queue; per request the shared distance/compare
// unit visits one vehicle slot a cycle, then each result waits in the output
// register until it is taken. Not ready meanwhile.
// Reset (async, active low) clears flags, queue count, tick count and threshold.
module nearest_idle_vehicle_dispatch #(
    parameter int QUEUE_DEPTH   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [15:0]                   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    mode,
    input  wire logic [4:0]                    vehicle_slot,
    input  wire logic                          vehicle_present,
    input  wire logic                          vehicle_cruising,
    input  wire logic [23:0]                   x_coord,
    input  wire logic [23:0]                   y_coord,
    input  wire logic [15:0]                   person_id,
    input  wire logic [31:0]                   start_node,
    input  wire logic [31:0]                   dest_node,
    input  wire logic                          nodes_found,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic [15:0]                        out_person_id,
    output logic [4:0]                         assigned_slot,
    output logic [31:0]                        out_start_node,
    output logic [31:0]                        out_dest_node,
    output logic [24:0]                        distance,
    output logic                               last
);
    import nivd_pkg::*;

    localparam int SA  = (VEHICLE_SLOTS > 1) ? $clog2(VEHICLE_SLOTS) : 1;
    localparam int QA  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC  = $clog2(QUEUE_DEPTH + 1);
    localparam int SC  = $clog2(VEHICLE_SLOTS + 1);
    localparam int CW  = COORD_BITS;
    localparam int DW  = COORD_BITS + 1;
    localparam int QW  = PERSON_W + 2 * NODE_W + 2 * CW + 1;
    localparam int VW  = 2 * CW;

    state_t state_reg, state_next;
    logic [TICK_W-1:0] thr_reg, tick_reg;
    logic [QC-1:0] count_reg, count_next, rd_reg, kept_reg;
    logic [SC-1:0] scan_reg;
    logic [VEHICLE_SLOTS-1:0] pres_reg, crus_reg;
    logic found_reg;
    logic [DW-1:0] best_reg;
    logic [SA-1:0] bslot_reg;
    logic [QW-1:0] cur_reg;

    // output register
    logic ov_reg;
    logic [1:0] st_o_reg;
    logic [PERSON_W-1:0] pid_o_reg;
    logic [SLOT_W-1:0] slot_o_reg;
    logic [NODE_W-1:0] sn_o_reg, dn_o_reg;
    logic [DIST_W-1:0] dist_o_reg;
    logic last_o_reg;

    // queue RAM
    logic q_we;
    logic [QA-1:0] q_waddr, q_raddr;
    logic [QW-1:0] q_wdata, q_rdata;
    nivd_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // vehicle position RAM
    logic v_we;
    logic [SA-1:0] v_raddr;
    logic [VW-1:0] v_rdata;
    nivd_ram #(.WIDTH(VW), .DEPTH(VEHICLE_SLOTS)) u_veh (
        .clk(clk), .we(v_we), .waddr(vehicle_slot[SA-1:0]),
        .wdata({x_coord[CW-1:0], y_coord[CW-1:0]}),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    logic in_fire, idle, slot_ok, is_round;
    assign idle      = (state_reg == S_IDLE);
    assign in_ready  = idle && !ov_reg;
    assign cfg_ready = in_ready;
    assign in_fire   = in_valid && in_ready;
    assign slot_ok   = ({27'd0, vehicle_slot} < 32'(VEHICLE_SLOTS));
    assign is_round  = (tick_reg == thr_reg);

    logic q_full;
    assign q_full = (count_reg >= QC'(QUEUE_DEPTH));

    assign v_we = in_fire && (mode_t'(mode) == MODE_UPDATE) && slot_ok;

    // current request fields
    logic [PERSON_W-1:0] c_pid;
    logic [NODE_W-1:0] c_sn, c_dn;
    logic [CW-1:0] c_x, c_y;
    logic c_ok;
    assign {c_pid, c_sn, c_dn, c_x, c_y, c_ok} = cur_reg;

    // shared distance unit: one slot per cycle, registered read data is one slot behind the address
    logic [SA-1:0] prev_slot;
    logic [CW-1:0] vx, vy, dx, dy;
    logic [DW-1:0] d;
    logic cand;
    assign {vx, vy} = v_rdata;
    assign dx = (c_x > vx) ? c_x - vx : vx - c_x;
    assign dy = (c_y > vy) ? c_y - vy : vy - c_y;
    assign d  = {1'b0, dx} + {1'b0, dy};
    assign prev_slot = SA'(scan_reg - SC'(1));
    assign cand = (scan_reg != '0) && pres_reg[prev_slot] && crus_reg[prev_slot];
    assign v_raddr = SA'(scan_reg);

    logic scan_done;
    assign scan_done = (scan_reg == SC'(VEHICLE_SLOTS)) || !c_ok;

    // present the next entry ahead of LOAD so its read data is ready there
    always_comb
    begin
        priority if (state_reg == S_IDLE)
            q_raddr = '0;
        else if (state_reg == S_EMIT && !ov_reg)
            q_raddr = QA'(rd_reg + QC'(1));
        else
            q_raddr = rd_reg[QA-1:0];
    end

    always_comb
    begin
        q_we = 1'b0;
        q_waddr = count_reg[QA-1:0];
        q_wdata = {person_id, start_node, dest_node, x_coord[CW-1:0], y_coord[CW-1:0],
                   nodes_found};
        if (in_fire && (mode_t'(mode) == MODE_REQUEST) && !q_full)
        begin
            q_we = 1'b1;
        end
        else if (state_reg == S_EMIT && c_ok && !found_reg)
        begin
            // keep retried request, compacted in order
            q_we = 1'b1;
            q_waddr = kept_reg[QA-1:0];
            q_wdata = cur_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (mode_t'(mode))
                        MODE_REQUEST:
                        begin
                            if (q_full)
                                state_next = S_FULL;
                            else
                                count_next = count_reg + QC'(1);
                        end
                        MODE_TICK:
                        begin
                            if (is_round && count_reg != '0)
                                state_next = S_LOAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD: state_next = S_SCAN;
            S_SCAN: if (scan_done) state_next = S_EMIT;
            S_EMIT:
            begin
                if (!ov_reg)
                begin
                    if (rd_reg + QC'(1) == count_reg)
                    begin
                        state_next = S_IDLE;
                        count_next = kept_reg + QC'((c_ok && !found_reg) ? 1 : 0);
                    end
                    else
                        state_next = S_LOAD;
                end
            end
            S_FULL: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            thr_reg   <= '0;
            tick_reg  <= '0;
            count_reg <= '0;
            pres_reg  <= '0;
            crus_reg  <= '0;
            ov_reg    <= 1'b0;
            rd_reg    <= '0;
            kept_reg  <= '0;
            scan_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
            if (out_valid && out_ready)
                ov_reg <= 1'b0;
            if (in_fire && mode_t'(mode) == MODE_TICK)
            begin
                tick_reg <= is_round ? '0 : tick_reg + TICK_W'(1);
                rd_reg   <= '0;
                kept_reg <= '0;
            end
            if (v_we)
            begin
                pres_reg[vehicle_slot[SA-1:0]] <= vehicle_present;
                crus_reg[vehicle_slot[SA-1:0]] <= vehicle_cruising;
            end
            if (state_reg == S_LOAD)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            if (state_reg == S_SCAN)
            begin
                if (cand && (!found_reg || d < best_reg))
                    found_reg <= 1'b1;
                scan_reg <= scan_reg + SC'(1);
            end
            if (state_reg == S_FULL)
                ov_reg <= 1'b1;
            if (state_reg == S_EMIT && !ov_reg)
            begin
                ov_reg <= 1'b1;
                rd_reg <= rd_reg + QC'(1);
                if (c_ok && !found_reg)
                    kept_reg <= kept_reg + QC'(1);
            end
        end
    end

    logic [PERSON_W-1:0] hold_pid;
    logic [NODE_W-1:0] hold_sn, hold_dn;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
            cur_reg <= q_rdata;
        if (state_reg == S_SCAN && cand && (!found_reg || d < best_reg))
        begin
            best_reg  <= d;
            bslot_reg <= prev_slot;
        end
        if (in_fire)
        begin
            hold_pid <= person_id;
            hold_sn  <= start_node;
            hold_dn  <= dest_node;
        end
        if (state_reg == S_FULL)
        begin
            st_o_reg   <= ST_FULL;
            pid_o_reg  <= hold_pid;
            slot_o_reg <= '0;
            sn_o_reg   <= hold_sn;
            dn_o_reg   <= hold_dn;
            dist_o_reg <= '0;
            last_o_reg <= 1'b1;
        end
        if (state_reg == S_EMIT && !ov_reg)
        begin
            st_o_reg   <= !c_ok ? ST_BAD_NODE : (found_reg ? ST_ASSIGNED : ST_RETRY);
            pid_o_reg  <= c_pid;
            slot_o_reg <= (c_ok && found_reg) ? SLOT_W'(bslot_reg) : '0;
            sn_o_reg   <= c_sn;
            dn_o_reg   <= c_dn;
            dist_o_reg <= (c_ok && found_reg) ? DIST_W'(best_reg) : '0;
            last_o_reg <= (rd_reg + QC'(1) == count_reg);
        end
    end

    assign out_valid      = ov_reg;
    assign status         = st_o_reg;
    assign out_person_id  = pid_o_reg;
    assign assigned_slot  = slot_o_reg;
    assign out_start_node = sn_o_reg;
    assign out_dest_node  = dn_o_reg;
    assign distance       = dist_o_reg;
    assign last           = last_o_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QC'(QUEUE_DEPTH))
        else $error("queue count overflow");
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= rd_reg)
        else $error("kept exceeds read");
endmodule
`default_nettype wire
